### hdl/bu9_pkg.sv
// bu9_pkg: shared types and constants for the nine-fold bilinear upscaler.
// Used by bu9_ctrl, bu9_dp, bu9_lane, bilinear_upscale_9x_top and tb. No dependencies.

package bu9_pkg;

  localparam int STEPS  = 9;   // interpolation steps per source cell, each direction
  localparam int STEP_W = 4;   // width of a step index / weight (0..9)
  localparam int PIX_W  = 16;

  typedef logic signed [PIX_W-1:0] pix_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // input transaction this cycle
    logic top_ld;    // lanes compute upper horizontal row
    logic bot_ld;    // lanes compute lower horizontal row
    logic ul_upd;    // upper-left pixel <= line store read data
    logic left_upd;  // left pixel <= current pixel
    logic ram_wr;    // write current pixel into line store
    logic t_clr;     // restart vertical step
    logic vt_step;   // lanes compute one output row into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;      // current pixel closes a source cell
    logic out_free;  // output register can take a new row
    logic t_last;    // vertical step is at the last row
  } sts_t;

endpackage

### hdl/bu9_ram.sv
// bu9_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the previous source row.

module bu9_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/bu9_lane.sv
// bu9_lane: one interpolation lane, y = a*(9-w)/9 + b*w/9, quotients truncated
// toward zero. Depends on bu9_pkg.

module bu9_lane (
  input  bu9_pkg::pix_t                a,
  input  bu9_pkg::pix_t                b,
  input  logic [bu9_pkg::STEP_W-1:0]   w,
  output bu9_pkg::pix_t                y
);

  // floor(x/9) == (x * ceil(2^24/9)) >> 24 for x < 2^21
  localparam logic [40:0] Div9Mul   = 41'd1864136;
  localparam int          Div9Shift = 24;

  // v * k for k in 0..9, as shift-add
  function automatic logic signed [19:0] wmul(input bu9_pkg::pix_t v,
                                              input logic [bu9_pkg::STEP_W-1:0] k);
    logic signed [19:0] e;
    logic signed [19:0] p;
    e = {{4{v[15]}}, v};
    case (k)
      4'd0:    p = '0;
      4'd1:    p = e;
      4'd2:    p = e <<< 1;
      4'd3:    p = (e <<< 1) + e;
      4'd4:    p = e <<< 2;
      4'd5:    p = (e <<< 2) + e;
      4'd6:    p = (e <<< 2) + (e <<< 1);
      4'd7:    p = (e <<< 3) - e;
      4'd8:    p = e <<< 3;
      4'd9:    p = (e <<< 3) + e;
      default: p = '0;
    endcase
    return p;
  endfunction

  // signed divide by nine, truncating toward zero
  function automatic logic signed [16:0] div9(input logic signed [19:0] x);
    logic [19:0] mag;
    logic [40:0] prod;
    logic [16:0] q;
    mag  = x[19] ? 20'(-x) : 20'(x);
    prod = {21'd0, mag} * Div9Mul;
    q    = prod[Div9Shift +: 17];
    return x[19] ? 17'(-q) : q;
  endfunction

  logic [bu9_pkg::STEP_W-1:0] wc;
  logic signed [16:0]         qa;
  logic signed [16:0]         qb;
  logic signed [17:0]         sum;

  always_comb begin
    wc  = bu9_pkg::STEP_W'(bu9_pkg::STEPS) - w;
    qa  = div9(wmul(a, wc));
    qb  = div9(wmul(b, w));
    sum = 18'(qa) + 18'(qb);
    y   = sum[15:0];
  end

endmodule

### hdl/bu9_ctrl.sv
// bu9_ctrl: sequencing state machine of the upscaler (accept, line store
// access, two horizontal passes, nine vertical rows). Depends on bu9_pkg.

module bu9_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bu9_pkg::sts_t sts,
  output bu9_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_HB   = 4'b0100,
    S_VT   = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        // line store data is out: upper row, store update
        cmd.top_ld = 1'b1;
        cmd.ul_upd = 1'b1;
        cmd.ram_wr = 1'b1;
        if (sts.emit) begin
          state_nxt = S_HB;
        end else begin
          cmd.left_upd = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_HB: begin
        cmd.bot_ld   = 1'b1;
        cmd.left_upd = 1'b1;
        cmd.t_clr    = 1'b1;
        state_nxt    = S_VT;
      end
      S_VT: begin
        if (sts.out_free) begin
          cmd.vt_step = 1'b1;
          if (sts.t_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

### hdl/bu9_dp.sv
// bu9_dp: upscaler datapath: raster counters, line store, neighbor pixels,
// nine shared interpolation lanes, output register. Depends on bu9_pkg,
// bu9_ram and bu9_lane.

module bu9_dp #(
  parameter int SRC_WIDTH  = 32,
  parameter int SRC_HEIGHT = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bu9_pkg::cmd_t cmd,
  output bu9_pkg::sts_t sts,
  input  bu9_pkg::pix_t in_sample,
  input  logic          in_frame_start,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [7:0]    out_row,
  output logic [8:0]    out_col,
  output bu9_pkg::pix_t out_pixel_0,
  output bu9_pkg::pix_t out_pixel_1,
  output bu9_pkg::pix_t out_pixel_2,
  output bu9_pkg::pix_t out_pixel_3,
  output bu9_pkg::pix_t out_pixel_4,
  output bu9_pkg::pix_t out_pixel_5,
  output bu9_pkg::pix_t out_pixel_6,
  output bu9_pkg::pix_t out_pixel_7,
  output bu9_pkg::pix_t out_pixel_8,
  output logic          out_last
);

  localparam int COL_W = $clog2(SRC_WIDTH);
  localparam int ROW_W = $clog2(SRC_HEIGHT);
  localparam int SW    = bu9_pkg::STEP_W;

  // raster position of the next pixel, and of the one being processed
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] item_col_r;
  logic [ROW_W-1:0] item_row_r;
  logic [COL_W-1:0] eff_col;
  logic [ROW_W-1:0] eff_row;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_nxt;

  bu9_pkg::pix_t cur_r;
  bu9_pkg::pix_t left_r;
  bu9_pkg::pix_t ul_r;
  bu9_pkg::pix_t up;
  logic [SW-1:0] t_r;

  bu9_pkg::pix_t top_r  [bu9_pkg::STEPS];
  bu9_pkg::pix_t bot_r  [bu9_pkg::STEPS];
  bu9_pkg::pix_t lane_a [bu9_pkg::STEPS];
  bu9_pkg::pix_t lane_b [bu9_pkg::STEPS];
  logic [SW-1:0] lane_w [bu9_pkg::STEPS];
  bu9_pkg::pix_t lane_y [bu9_pkg::STEPS];

  logic          out_valid_r;
  logic [7:0]    out_row_r;
  logic [8:0]    out_col_r;
  bu9_pkg::pix_t pix_r [bu9_pkg::STEPS];
  logic          last_r;
  logic [7:0]    row8;
  logic [8:0]    col9;
  logic [7:0]    out_row_nxt;
  logic [8:0]    out_col_nxt;

  // frame_start overrides the running position; wrap after the last pixel
  always_comb begin
    eff_col = in_frame_start ? '0 : col_r;
    eff_row = in_frame_start ? '0 : row_r;
    if (eff_col == COL_W'(SRC_WIDTH - 1)) begin
      col_nxt = '0;
      row_nxt = (eff_row == ROW_W'(SRC_HEIGHT - 1)) ? '0 : eff_row + 1'b1;
    end else begin
      col_nxt = eff_col + 1'b1;
      row_nxt = eff_row;
    end
  end

  bu9_ram #(
    .WIDTH (bu9_pkg::PIX_W),
    .DEPTH (SRC_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (cmd.ram_wr),
    .waddr (item_col_r),
    .wdata (cur_r),
    .re    (cmd.accept),
    .raddr (eff_col),
    .rdata (up)
  );

  // lane operands: horizontal passes weight by lane index, vertical by t
  always_comb begin
    for (int i = 0; i < bu9_pkg::STEPS; i++) begin
      if (cmd.vt_step) begin
        lane_a[i] = top_r[i];
        lane_b[i] = bot_r[i];
        lane_w[i] = t_r;
      end else if (cmd.bot_ld) begin
        lane_a[i] = left_r;
        lane_b[i] = cur_r;
        lane_w[i] = SW'(i);
      end else begin
        lane_a[i] = ul_r;
        lane_b[i] = up;
        lane_w[i] = SW'(i);
      end
    end
  end

  for (genvar g = 0; g < bu9_pkg::STEPS; g++) begin : g_lane
    bu9_lane u_lane (
      .a (lane_a[g]),
      .b (lane_b[g]),
      .w (lane_w[g]),
      .y (lane_y[g])
    );
  end

  always_comb begin
    row8        = 8'(item_row_r) - 8'd1;
    col9        = 9'(item_col_r) - 9'd1;
    out_row_nxt = (row8 << 3) + row8 + 8'(t_r);
    out_col_nxt = (col9 << 3) + col9;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      ul_r        <= '0;
      t_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (cmd.ul_upd) begin
        ul_r <= up;
      end
      if (cmd.left_upd) begin
        left_r <= cur_r;
      end
      if (cmd.t_clr) begin
        t_r <= '0;
      end else if (cmd.vt_step) begin
        t_r <= t_r + 1'b1;
      end
      if (cmd.vt_step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_r      <= in_sample;
      item_col_r <= eff_col;
      item_row_r <= eff_row;
    end
    for (int i = 0; i < bu9_pkg::STEPS; i++) begin
      if (cmd.top_ld) begin
        top_r[i] <= lane_y[i];
      end
      if (cmd.bot_ld) begin
        bot_r[i] <= lane_y[i];
      end
      if (cmd.vt_step) begin
        pix_r[i] <= lane_y[i];
      end
    end
    if (cmd.vt_step) begin
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      last_r    <= (t_r == SW'(bu9_pkg::STEPS - 1));
    end
  end

  assign sts.emit     = (item_row_r != '0) && (item_col_r != '0);
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.t_last   = (t_r == SW'(bu9_pkg::STEPS - 1));

  assign out_valid   = out_valid_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_pixel_0 = pix_r[0];
  assign out_pixel_1 = pix_r[1];
  assign out_pixel_2 = pix_r[2];
  assign out_pixel_3 = pix_r[3];
  assign out_pixel_4 = pix_r[4];
  assign out_pixel_5 = pix_r[5];
  assign out_pixel_6 = pix_r[6];
  assign out_pixel_7 = pix_r[7];
  assign out_pixel_8 = pix_r[8];
  assign out_last    = last_r;

endmodule

### hdl/bilinear_upscale_9x_top.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_sample[15:0] s, in_frame_start
// out     | output    | out_valid / out_ready | out_row, out_col, out_pixel_0..8, out_last
//
// A pixel that closes no cell passes through accept and line store read/write.
// A pixel that closes a cell passes through accept, line store read with upper
// row, lower row, then one output row per cycle while the output register can
// take it, through the nine shared interpolation lanes.
// in_ready is high only between pixels; the last row may still wait in the
// output register while the next pixel is taken. Synchronous active-low reset;
// the line store is not cleared.
// Depends on bu9_pkg, bu9_ctrl, bu9_dp (bu9_ram, bu9_lane).

module bilinear_upscale_9x_top #(
  parameter int SRC_WIDTH  = 32,
  parameter int SRC_HEIGHT = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bu9_pkg::pix_t in_sample,
  input  logic          in_frame_start,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_row,
  output logic [8:0]    out_col,
  output bu9_pkg::pix_t out_pixel_0,
  output bu9_pkg::pix_t out_pixel_1,
  output bu9_pkg::pix_t out_pixel_2,
  output bu9_pkg::pix_t out_pixel_3,
  output bu9_pkg::pix_t out_pixel_4,
  output bu9_pkg::pix_t out_pixel_5,
  output bu9_pkg::pix_t out_pixel_6,
  output bu9_pkg::pix_t out_pixel_7,
  output bu9_pkg::pix_t out_pixel_8,
  output logic          out_last
);

  bu9_pkg::cmd_t cmd;
  bu9_pkg::sts_t sts;

  bu9_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bu9_dp #(
    .SRC_WIDTH  (SRC_WIDTH),
    .SRC_HEIGHT (SRC_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample      (in_sample),
    .in_frame_start (in_frame_start),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_pixel_0    (out_pixel_0),
    .out_pixel_1    (out_pixel_1),
    .out_pixel_2    (out_pixel_2),
    .out_pixel_3    (out_pixel_3),
    .out_pixel_4    (out_pixel_4),
    .out_pixel_5    (out_pixel_5),
    .out_pixel_6    (out_pixel_6),
    .out_pixel_7    (out_pixel_7),
    .out_pixel_8    (out_pixel_8),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  // a transaction is never followed directly by another one
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted in consecutive cycles");

  // output row is loaded only when the output register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.vt_step |-> sts.out_free)
    else $error("output register overwritten");

  // the ninth row of a block carries the last flag
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.vt_step && sts.t_last |=> out_valid && out_last)
    else $error("last flag missing on final row");

  // no new pixel is taken while rows of a block are being produced
  a_no_accept_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.vt_step |-> !in_ready)
    else $error("input ready during block output");
`endif

endmodule

### dv/tb.sv
// tb: self-checking bench for bilinear_upscale_9x_top (nine-fold bilinear upscaler).
// Holds a scoreboard class that predicts every row segment from the accepted pixels.
// Depends on bu9_pkg and the bilinear_upscale_9x_top RTL.
`timescale 1ns / 100ps

module tb;

  typedef bu9_pkg::pix_t pix_t;

  localparam int   STEPS       = bu9_pkg::STEPS;
  localparam int   SRC_W       = 32;
  localparam int   SRC_H       = 24;
  localparam int   IDLE_PCT    = 21;
  localparam int   N_ITEMS     = 160;
  localparam int   CYCLE_LIMIT = 500_000;
  localparam int   DRAIN_WAIT  = 40;
  localparam int   MAX_REPORTS = 10;
  localparam pix_t PIX_MIN     = 16'sh8000;
  localparam pix_t PIX_MAX     = 16'sh7fff;

  typedef struct {
    logic [7:0] row;
    logic [8:0] col;
    pix_t       px[STEPS];
    logic       is_last;
  } seg_t;

  class upscale_scoreboard;
    int   line_buf[SRC_W];
    int   left_px;
    int   upleft_px;
    int   col_cnt;
    int   row_cnt;
    seg_t expected_segs[$];
    int   mismatches;
    int   n_checked;

    function new();
      foreach (line_buf[i]) line_buf[i] = 0;
      left_px    = 0;
      upleft_px  = 0;
      col_cnt    = 0;
      row_cnt    = 0;
      mismatches = 0;
      n_checked  = 0;
    endfunction

    // a*(9-s)/9 + b*s/9, each quotient truncated toward zero
    function int interp9(int a, int b, int s);
      return a * (STEPS - s) / STEPS + b * s / STEPS;
    endfunction

    function string seg_text(seg_t sg);
      return $sformatf("row=%0d col=%0d px=%0d %0d %0d %0d %0d %0d %0d %0d %0d last=%0b",
                       sg.row, sg.col, sg.px[0], sg.px[1], sg.px[2], sg.px[3], sg.px[4],
                       sg.px[5], sg.px[6], sg.px[7], sg.px[8], sg.is_last);
    endfunction

    function int pending();
      return expected_segs.size();
    endfunction

    // accepted pixel transaction: update state, queue the 9x9 block it closes
    function void note_pixel(pix_t smp, logic fs);
      int   cur;
      int   up;
      int   top_h[STEPS];
      int   bot_h[STEPS];
      int   s;
      int   t;
      seg_t sg;
      cur = smp;
      if (fs) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      up = line_buf[col_cnt];
      if (row_cnt > 0 && col_cnt > 0) begin
        for (s = 0; s < STEPS; s++) begin
          top_h[s] = interp9(upleft_px, up, s);
          bot_h[s] = interp9(left_px, cur, s);
        end
        for (t = 0; t < STEPS; t++) begin
          sg.row = 8'((row_cnt - 1) * STEPS + t);
          sg.col = 9'((col_cnt - 1) * STEPS);
          for (s = 0; s < STEPS; s++) sg.px[s] = pix_t'(interp9(top_h[s], bot_h[s], t));
          sg.is_last = (t == STEPS - 1);
          expected_segs.push_back(sg);
        end
      end
      upleft_px         = up;
      left_px           = cur;
      line_buf[col_cnt] = cur;
      col_cnt++;
      if (col_cnt >= SRC_W) begin
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= SRC_H) row_cnt = 0;
      end
    endfunction

    function void check_segment(seg_t got);
      seg_t exp_seg;
      bit   bad;
      int   s;
      n_checked++;
      if (expected_segs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected row segment: %s", seg_text(got));
        return;
      end
      exp_seg = expected_segs.pop_front();
      bad = (got.row !== exp_seg.row) || (got.col !== exp_seg.col) ||
            (got.is_last !== exp_seg.is_last);
      for (s = 0; s < STEPS; s++)
        if (got.px[s] !== exp_seg.px[s]) bad = 1'b1;
      if (bad) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("row segment mismatch at %0t", $time);
          $display("  expected %s", seg_text(exp_seg));
          $display("  actual   %s", seg_text(got));
        end
      end
    endfunction
  endclass

  logic clk            = 1'b0;
  logic rst_n          = 1'b0;
  logic in_valid       = 1'b0;
  logic in_ready;
  pix_t in_sample      = '0;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_ready      = 1'b0;
  logic [7:0] out_row;
  logic [8:0] out_col;
  pix_t out_pixel_0, out_pixel_1, out_pixel_2, out_pixel_3, out_pixel_4;
  pix_t out_pixel_5, out_pixel_6, out_pixel_7, out_pixel_8;
  logic out_last;

  upscale_scoreboard sb = new();
  bit   idle_en         = 1'b1;
  int   cycles          = 0;
  int   n_pixels        = 0;
  int   n_restarts      = 0;
  seg_t got_seg;

  always #1 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  bilinear_upscale_9x_top #(
    .SRC_WIDTH (SRC_W),
    .SRC_HEIGHT(SRC_H)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_frame_start(in_frame_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_pixel_0   (out_pixel_0),
    .out_pixel_1   (out_pixel_1),
    .out_pixel_2   (out_pixel_2),
    .out_pixel_3   (out_pixel_3),
    .out_pixel_4   (out_pixel_4),
    .out_pixel_5   (out_pixel_5),
    .out_pixel_6   (out_pixel_6),
    .out_pixel_7   (out_pixel_7),
    .out_pixel_8   (out_pixel_8),
    .out_last      (out_last)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_seg.row     = out_row;
      got_seg.col     = out_col;
      got_seg.px[0]   = out_pixel_0;
      got_seg.px[1]   = out_pixel_1;
      got_seg.px[2]   = out_pixel_2;
      got_seg.px[3]   = out_pixel_3;
      got_seg.px[4]   = out_pixel_4;
      got_seg.px[5]   = out_pixel_5;
      got_seg.px[6]   = out_pixel_6;
      got_seg.px[7]   = out_pixel_7;
      got_seg.px[8]   = out_pixel_8;
      got_seg.is_last = out_last;
      sb.check_segment(got_seg);
    end
  end

  function automatic pix_t pick_sample(bit extremes_only);
    case ($urandom_range(extremes_only ? 3 : 9))
      0: return PIX_MIN;
      1: return PIX_MAX;
      2: return '0;
      3: return -16'sd1;
      default: return pix_t'($urandom);
    endcase
  endfunction

  // one pixel transaction; valid only drops when a gap is taken
  task automatic send_pixel(input pix_t smp, input logic fs);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= smp;
    in_frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(smp, fs);
    n_pixels++;
    if (fs) n_restarts++;
  endtask

  initial begin
    wait (cycles == CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("[bilinear_upscale_9x_top] ERROR");
    $finish;
  end

  initial begin
    int   k;
    int   fr;
    int   flen;
    int   nfill;
    bit   ext;
    pix_t directed_px[$];

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // top row only: extremes, no output; frame restart in mid-row
    directed_px = '{PIX_MIN, PIX_MAX, 16'sd0, -16'sd1, 16'sd1, PIX_MIN, PIX_MAX,
                    16'sh5555, 16'shaaaa, 16'sh00ff, 16'shff00};
    foreach (directed_px[i]) send_pixel(directed_px[i], 1'b0);
    foreach (directed_px[i]) send_pixel(directed_px[i], i == 0);

    // two short frames, the second made of extremes only,
    // plus the odd stray frame start
    for (fr = 0; fr < 2; fr++) begin
      flen = $urandom_range(SRC_W + 2, SRC_W + 16);
      ext  = (fr == 1);
      for (k = 0; k < flen; k++)
        send_pixel(pick_sample(ext), (k == 0) || ($urandom_range(39) == 0));
    end

    // last frame fills up the item budget; its second row runs without idling
    nfill = N_ITEMS - n_pixels;
    for (k = 0; k < nfill; k++) begin
      idle_en = !(k >= SRC_W && k < 2 * SRC_W);
      send_pixel(pick_sample(($urandom_range(7) == 0)), k == 0);
    end
    idle_en = 1'b1;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d pixels (%0d frame starts) sent, %0d row segments checked, %0d mismatches",
             n_pixels, n_restarts, sb.n_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[bilinear_upscale_9x_top] OK");
    end else begin
      $display("[bilinear_upscale_9x_top] ERROR");
    end
    $finish;
  end

endmodule

### bilinear_upscale_9x_top.f
hdl/bu9_pkg.sv
hdl/bu9_ram.sv
hdl/bu9_lane.sv
hdl/bu9_ctrl.sv
hdl/bu9_dp.sv
hdl/bilinear_upscale_9x_top.sv
dv/tb.sv
